FILE: design/mssr_pkg.sv
// shared types, constants and arithmetic helpers for the servo slew ramp block
package mssr_pkg;

    // field widths
    localparam int PULSE_W = 16;
    localparam int CFG_W   = 15;
    localparam int ANGLE_W = 8;
    localparam int JOINT_W = 3;
    localparam int QUO_W   = 8;
    localparam int PROD_W  = 16;

    // joint counts
    localparam int JOINTS_DEF  = 5;
    localparam int MAX_JOINTS  = 8;
    localparam int REPORTED    = 5;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // register map, indexed by paddr[2]
    localparam int  ADDR_W         = 3;
    localparam logic REG_PULSE_MIN  = 1'b0;
    localparam logic REG_PULSE_SPAN = 1'b1;

    // angle scaling: x / 180 as (x * RECIP) >> RECIP_SHIFT, exact for x < 2^16
    localparam logic [ANGLE_W-1:0] MAX_ANGLE   = 8'd180;
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [15:0]        RECIP       = 16'd46604;

    // reset values
    localparam logic [CFG_W-1:0] PULSE_MIN_RST  = 15'd2000;
    localparam logic [CFG_W-1:0] PULSE_SPAN_RST = 15'd2000;
    localparam int SPAN_QUO_RST_I = 2000 / 180;
    localparam int SPAN_REM_RST_I = 2000 % 180;

    // home angles, joints beyond claw home at 90 degrees
    localparam logic [ANGLE_W-1:0] HOME_ANGLE [MAX_JOINTS] = '{
        8'd90, 8'd65, 8'd180, 8'd90, 8'd150, 8'd90, 8'd90, 8'd90
    };

    // scaling config: span split into span = 180 * quo + rem
    typedef struct packed {
        logic [CFG_W-1:0] pulse_min;
        logic [QUO_W-1:0] span_quo;
        logic [QUO_W-1:0] span_rem;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        pulse_min: PULSE_MIN_RST,
        span_quo:  QUO_W'(SPAN_QUO_RST_I),
        span_rem:  QUO_W'(SPAN_REM_RST_I)
    };

    // one item on its way to the joint state
    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic [JOINT_W-1:0] joint;
        logic               reject;
        logic [PULSE_W-1:0] target;
    } t_step;

    // floor(z / 180) for z below 2^15, result below 256
    function automatic logic [QUO_W-1:0] div180(input logic [PROD_W-1:0] z);
        logic [31:0] p;
        p = 32'(z) * 32'(RECIP);
        return p[RECIP_SHIFT +: QUO_W];
    endfunction

    // pulse_min + floor(deg * span / 180), used for the home positions
    function automatic logic [PULSE_W-1:0] pulse_of(input t_cfg c,
                                                    input logic [ANGLE_W-1:0] deg);
        logic [PROD_W-1:0] pq;
        logic [PROD_W-1:0] pr;
        logic [PULSE_W:0]  s;
        pq = PROD_W'(deg) * PROD_W'(c.span_quo);
        pr = PROD_W'(deg) * PROD_W'(c.span_rem);
        s  = (PULSE_W+1)'(c.pulse_min) + (PULSE_W+1)'(pq) + (PULSE_W+1)'(div180(pr));
        return s[PULSE_W-1:0];
    endfunction

endpackage

FILE: design/mssr_item_if.sv
// input item channel of the servo slew ramp block
interface mssr_item_if;
    import mssr_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [JOINT_W-1:0] joint;
    logic [ANGLE_W-1:0] angle;

    modport source (output valid, cmd, joint, angle, input ready);
    modport sink   (input valid, cmd, joint, angle, output ready);
endinterface

FILE: design/mssr_result_if.sv
// result item channel of the servo slew ramp block
interface mssr_result_if;
    import mssr_pkg::*;

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_base;
    logic [PULSE_W-1:0] pulse_arm_two;
    logic [PULSE_W-1:0] pulse_arm_three;
    logic [PULSE_W-1:0] pulse_arm_four;
    logic [PULSE_W-1:0] pulse_claw;
    logic               rejected;
    logic               all_settled;

    modport source (output valid, pulse_base, pulse_arm_two, pulse_arm_three,
                    pulse_arm_four, pulse_claw, rejected, all_settled, input ready);
    modport sink   (input valid, pulse_base, pulse_arm_two, pulse_arm_three,
                    pulse_arm_four, pulse_claw, rejected, all_settled, output ready);
endinterface

FILE: design/mssr_cfg.sv
// apb register file, span split and home pulse table
module mssr_cfg #(
    parameter int JOINTS = mssr_pkg::JOINTS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [mssr_pkg::ADDR_W-1:0]                 paddr,
    input  logic [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready,
    output mssr_pkg::t_cfg                              o_cfg,
    output logic [JOINTS-1:0][mssr_pkg::PULSE_W-1:0]    o_home
);
    import mssr_pkg::*;

    logic [CFG_W-1:0] r_pulse_min;
    logic [CFG_W-1:0] r_pulse_span;
    logic [QUO_W-1:0] r_span_quo;
    logic [QUO_W-1:0] r_span_rem;
    logic [QUO_W-1:0] n_span_quo;
    logic [QUO_W-1:0] n_span_rem;
    logic [JOINTS-1:0][PULSE_W-1:0] r_home;
    logic             wr_en;
    t_cfg             cfg;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // split the written span into quotient and remainder by 180
    always_comb begin
        n_span_quo = div180(PROD_W'(pwdata[CFG_W-1:0]));
        n_span_rem = QUO_W'(pwdata[CFG_W-1:0]
                     - CFG_W'(PROD_W'(n_span_quo) * PROD_W'(MAX_ANGLE)));
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min  <= PULSE_MIN_RST;
            r_pulse_span <= PULSE_SPAN_RST;
            r_span_quo   <= CFG_RST.span_quo;
            r_span_rem   <= CFG_RST.span_rem;
        end else if (wr_en) begin
            case (paddr[2])
                REG_PULSE_MIN: begin
                    r_pulse_min <= pwdata[CFG_W-1:0];
                end
                REG_PULSE_SPAN: begin
                    r_pulse_span <= pwdata[CFG_W-1:0];
                    r_span_quo   <= n_span_quo;
                    r_span_rem   <= n_span_rem;
                end
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[2])
            REG_PULSE_MIN:  prdata = 32'(r_pulse_min);
            REG_PULSE_SPAN: prdata = 32'(r_pulse_span);
            default:        prdata = '0;
        endcase
    end

    assign cfg.pulse_min = r_pulse_min;
    assign cfg.span_quo  = r_span_quo;
    assign cfg.span_rem  = r_span_rem;
    assign o_cfg         = cfg;

    // home pulses are registered from the config and follow it in the next cycle
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < JOINTS; g++) begin
            if (!i_rst_n) begin
                r_home[g] <= pulse_of(CFG_RST, HOME_ANGLE[g]);
            end else begin
                r_home[g] <= pulse_of(cfg, HOME_ANGLE[g]);
            end
        end
    end

    assign o_home = r_home;

endmodule

FILE: design/mssr_target.sv
// two stage pipeline from input item to checked target pulse
module mssr_target #(
    parameter int JOINTS = mssr_pkg::JOINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_valid,
    input  logic                          i_cmd,
    input  logic [mssr_pkg::JOINT_W-1:0]  i_joint,
    input  logic [mssr_pkg::ANGLE_W-1:0]  i_angle,
    input  mssr_pkg::t_cfg                i_cfg,
    output mssr_pkg::t_step               o_step
);
    import mssr_pkg::*;

    logic               r_s1_valid;
    logic               r_s1_cmd;
    logic [JOINT_W-1:0] r_s1_joint;
    logic               r_s1_reject;
    logic [PROD_W-1:0]  r_s1_pq;
    logic [PROD_W-1:0]  r_s1_pr;
    logic               n_s1_reject;
    t_step              r_s2;
    t_step              n_s2;

    // bad joint or angle on a set-target
    always_comb begin
        n_s1_reject = (i_cmd == CMD_SET)
                      && (({1'b0, i_joint} >= (JOINT_W+1)'(JOINTS)) || (i_angle > MAX_ANGLE));
    end

    // stage one: capture item and the two partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_advance) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_cmd    <= i_cmd;
            r_s1_joint  <= i_joint;
            r_s1_reject <= n_s1_reject;
            r_s1_pq     <= PROD_W'(i_angle) * PROD_W'(i_cfg.span_quo);
            r_s1_pr     <= PROD_W'(i_angle) * PROD_W'(i_cfg.span_rem);
        end
    end

    // stage two: pulse_min + quotient part + scaled remainder part
    always_comb begin
        n_s2.valid  = r_s1_valid;
        n_s2.cmd    = r_s1_cmd;
        n_s2.joint  = r_s1_joint;
        n_s2.reject = r_s1_reject;
        n_s2.target = PULSE_W'((PULSE_W+1)'(i_cfg.pulse_min) + (PULSE_W+1)'(r_s1_pq)
                      + (PULSE_W+1)'(div180(r_s1_pr)));
    end

    // only the valid flag needs a reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_advance) begin
            r_s2 <= n_s2;
        end
    end

    assign o_step = r_s2;

endmodule

FILE: design/mssr_joints.sv
// joint pulse and target state, slew step and result register
module mssr_joints #(
    parameter int JOINTS = mssr_pkg::JOINTS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  mssr_pkg::t_step                                   i_step,
    input  logic [JOINTS-1:0][mssr_pkg::PULSE_W-1:0]          i_home,
    input  logic                                              i_ready,
    output logic                                              o_advance,
    output logic                                              o_valid,
    output logic [mssr_pkg::REPORTED-1:0][mssr_pkg::PULSE_W-1:0] o_pulse,
    output logic                                              o_rejected,
    output logic                                              o_settled
);
    import mssr_pkg::*;

    logic [JOINTS-1:0][PULSE_W-1:0]   r_pulse;
    logic [JOINTS-1:0][PULSE_W-1:0]   r_target;
    logic [JOINTS-1:0][PULSE_W-1:0]   n_pulse;
    logic [JOINTS-1:0][PULSE_W-1:0]   n_target;
    logic                             r_home_pending;
    logic                             n_home_pending;
    logic                             n_settled;
    logic [REPORTED-1:0][PULSE_W-1:0] n_report;
    logic                             r_out_valid;
    logic [REPORTED-1:0][PULSE_W-1:0] r_out_pulse;
    logic                             r_out_rejected;
    logic                             r_out_settled;
    logic                             advance;
    logic                             commit;

    // whole pipeline moves when the result register is free or taken
    assign advance   = !r_out_valid || i_ready;
    assign commit    = advance && i_step.valid;
    assign o_advance = advance;

    // next joint state for the item in the last stage
    always_comb begin
        n_pulse        = r_pulse;
        n_target       = r_target;
        n_home_pending = r_home_pending;
        if (i_step.cmd == CMD_SET) begin
            if (!i_step.reject) begin
                if (r_home_pending) begin
                    n_pulse        = i_home;
                    n_target       = i_home;
                    n_home_pending = 1'b0;
                end
                for (int i = 0; i < JOINTS; i++) begin
                    if (i_step.joint == JOINT_W'(i)) begin
                        n_target[i] = i_step.target;
                    end
                end
            end
        end else begin
            for (int i = 0; i < JOINTS; i++) begin
                if (r_pulse[i] < r_target[i]) begin
                    n_pulse[i] = r_pulse[i] + 1'b1;
                end else if (r_pulse[i] > r_target[i]) begin
                    n_pulse[i] = r_pulse[i] - 1'b1;
                end
            end
        end
    end

    // settled check on the updated state
    always_comb begin
        n_settled = 1'b1;
        for (int i = 0; i < JOINTS; i++) begin
            if (n_pulse[i] != n_target[i]) begin
                n_settled = 1'b0;
            end
        end
    end

    // reported channels, missing joints read zero
    for (genvar g = 0; g < REPORTED; g++) begin : g_report
        if (g < JOINTS) begin : g_present
            assign n_report[g] = n_pulse[g];
        end else begin : g_absent
            assign n_report[g] = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse        <= '0;
            r_target       <= '0;
            r_home_pending <= 1'b1;
        end else if (commit) begin
            r_pulse        <= n_pulse;
            r_target       <= n_target;
            r_home_pending <= n_home_pending;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_step.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_pulse    <= n_report;
            r_out_rejected <= i_step.reject;
            r_out_settled  <= n_settled;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_pulse    = r_out_pulse;
    assign o_rejected = r_out_rejected;
    assign o_settled  = r_out_settled;

    // before homing every joint sits at zero
    a_zero_before_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_home_pending |-> (r_pulse == '0 && r_target == '0))
        else $error("joint state moved before homing");

    // a rejected set-target leaves the joints alone
    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && i_step.reject) |=> (r_pulse == $past(r_pulse)
                                       && r_target == $past(r_target)
                                       && r_home_pending == $past(r_home_pending)))
        else $error("rejected item changed joint state");

    // a tick moves joint 0 by at most one count
    a_tick_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && i_step.cmd == CMD_TICK && !r_home_pending)
        |=> ((r_pulse[0] - $past(r_pulse[0])) == 16'd0
             || (r_pulse[0] - $past(r_pulse[0])) == 16'd1
             || (r_pulse[0] - $past(r_pulse[0])) == 16'hFFFF))
        else $error("tick moved a joint by more than one count");

    // results before homing report settled
    a_settled_before_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_home_pending && n_home_pending) |=> r_out_settled)
        else $error("unhomed joints reported as moving");

endmodule

FILE: design/multi_servo_slew_ramp.sv
// An item is accepted every clock cycle when the result side keeps up. Its result item
// passes three registers: one for the angle products, one for the target pulse and the
// result register that also commits the joint state. A stalled result stalls all three
// stages together. pulse_span writes are split into a quotient and remainder by 180
// at the write itself; the home pulse table follows the config in the next cycle.
module multi_servo_slew_ramp #(
    parameter int JOINTS = mssr_pkg::JOINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mssr_item_if.sink                    i_item,
    mssr_result_if.source                o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mssr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mssr_pkg::*;

    t_cfg                             cfg;
    logic [JOINTS-1:0][PULSE_W-1:0]   home;
    t_step                            step;
    logic                             advance;
    logic [REPORTED-1:0][PULSE_W-1:0] pulse;

    // config registers
    mssr_cfg #(.JOINTS(JOINTS)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_home  (home)
    );

    // target computation
    mssr_target #(.JOINTS(JOINTS)) u_target (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (i_item.valid),
        .i_cmd     (i_item.cmd),
        .i_joint   (i_item.joint),
        .i_angle   (i_item.angle),
        .i_cfg     (cfg),
        .o_step    (step)
    );

    // joint state and result
    mssr_joints #(.JOINTS(JOINTS)) u_joints (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_home     (home),
        .i_ready    (o_result.ready),
        .o_advance  (advance),
        .o_valid    (o_result.valid),
        .o_pulse    (pulse),
        .o_rejected (o_result.rejected),
        .o_settled  (o_result.all_settled)
    );

    assign i_item.ready             = advance;
    assign o_result.pulse_base      = pulse[0];
    assign o_result.pulse_arm_two   = pulse[1];
    assign o_result.pulse_arm_three = pulse[2];
    assign o_result.pulse_arm_four  = pulse[3];
    assign o_result.pulse_claw      = pulse[4];

endmodule
